### rtl/core/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m: lbl");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error("%m: lbl");

`endif

### rtl/core/dtoi_pkg.sv
package dtoi_pkg;

  typedef enum logic [2:0] {
    CMD_D   = 3'd0,
    CMD_DZ  = 3'd1,
    CMD_W   = 3'd2,
    CMD_WZ  = 3'd3,
    CMD_CLR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_ZERO    = 2'd1,
    RM_UP      = 2'd2,
    RM_DOWN    = 2'd3
  } rmode_e;

  localparam logic [63:0] DW_POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DW_NEG_LIM = 64'h8000_0000_0000_0000;
  localparam logic [63:0] W_POS_LIM  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] W_NEG_LIM  = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic [63:0] res;
    logic        inx;
    logic        inc;
    logic        bad;
    logic        clr;
    logic        conv;
  } conv_t;

endpackage

### rtl/core/dtoi_datapath.sv
module dtoi_datapath import dtoi_pkg::*; (
  input  logic [2:0]  cmd_i,
  input  logic [63:0] operand_bits_i,
  input  logic [1:0]  rounding_mode_i,
  output conv_t       conv_o
);

  logic        word, neg, is_nan_inf, huge, inx, inc, gt, eq;
  logic [1:0]  mode;
  logic [10:0] expf;
  logic [52:0] m;
  logic [12:0] s;
  logic [11:0] r;
  logic [63:0] ip, rem, half, mask, mag, pos_lim, neg_lim, magx;
  logic [5:0]  rs;

  always_comb begin
    word = (cmd_i == CMD_W) || (cmd_i == CMD_WZ);
    mode = ((cmd_i == CMD_DZ) || (cmd_i == CMD_WZ)) ? RM_ZERO : rounding_mode_i;
    neg = operand_bits_i[63];
    expf = operand_bits_i[62:52];
    is_nan_inf = (expf == 11'h7FF);
    if (is_nan_inf && (operand_bits_i[51:0] != '0)) neg = 1'b1;
    m = {(expf != '0), operand_bits_i[51:0]};
    s = ((expf == '0) ? 13'd1 : {2'b0, expf}) - 13'd1075;
    huge = !s[12] && (s > 13'd11);
    r = 12'(-s);
    rs = r[5:0];
    ip = '0; rem = '0; half = '0; mask = '0; gt = 1'b0; eq = 1'b0;
    inx = 1'b0; inc = 1'b0; mag = '0;
    if (!s[12]) begin
      mag = {11'b0, m} << s[3:0];
    end else begin
      if (r >= 12'd64) begin
        rem = {11'b0, m};
      end else begin
        mask = (64'd1 << rs) - 64'd1;
        ip = {11'b0, m} >> rs;
        rem = {11'b0, m} & mask;
        half = 64'd1 << (rs - 6'd1);
        gt = rem > half;
        eq = rem == half;
      end
      inx = rem != '0;
      if (inx) begin
        case (mode)
          RM_NEAREST: inc = gt || (eq && ip[0]);
          RM_UP:      inc = !neg;
          RM_DOWN:    inc = neg;
          default:    inc = 1'b0;
        endcase
      end
      mag = ip + {63'b0, inc};
    end
    pos_lim = word ? W_POS_LIM : DW_POS_LIM;
    neg_lim = word ? W_NEG_LIM : DW_NEG_LIM;
    magx = 64'(-mag);
    conv_o.clr = (cmd_i == CMD_CLR);
    conv_o.conv = (cmd_i < CMD_CLR);
    conv_o.bad = conv_o.conv && (is_nan_inf || huge ||
                 (neg ? (mag > neg_lim) : (mag > pos_lim)));
    conv_o.inx = 1'b0;
    conv_o.inc = 1'b0;
    conv_o.res = '0;
    if (conv_o.bad) begin
      conv_o.res = neg ? neg_lim : pos_lim;
    end else if (conv_o.conv) begin
      conv_o.res = neg ? magx : mag;
      if (word) conv_o.res[63:32] = '0;
      conv_o.inx = inx;
      conv_o.inc = inc;
    end
  end

endmodule

### rtl/core/double_to_int_convert_core.sv
// Result path: input register, then result register, which loads only when the output has space.
// Throughput: one item per cycle while the output is not stalled; one shifter/incrementer/compare pass.
// Output register is skid-free: input ready follows output space.
// Reset: asynchronous active low; clears valids, sticky flag and rounding mode
// (nearest even).
`include "assert_macros.svh"
module double_to_int_convert_core import dtoi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] operand_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_bits_o,
  output logic        inexact_o,
  output logic        rounded_up_magnitude_o,
  output logic        invalid_sticky_o,
  output logic        summary_set_o
);

  logic [1:0]  rmode_q;
  logic        s1_valid_q, out_valid_q, flag_q, flag_d;
  logic [2:0]  cmd_q;
  logic [63:0] op_q;
  logic        s1_adv, out_load;
  conv_t       conv;
  logic [63:0] res_q;
  logic        inx_q, inc_q, sticky_q, sum_q;

  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_adv     = !s1_valid_q || out_load;
  assign in_ready_o = s1_adv;

  dtoi_datapath u_dp (
    .cmd_i          (cmd_q),
    .operand_bits_i (op_q),
    .rounding_mode_i(rmode_q),
    .conv_o         (conv)
  );

  always_comb begin
    flag_d = flag_q;
    if (conv.clr) flag_d = 1'b0;
    else if (conv.bad) flag_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmode_q     <= RM_NEAREST;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
    end else begin
      if (cfg_we_i) rmode_q <= cfg_wdata_i;
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
        flag_q      <= flag_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      cmd_q <= cmd_i;
      op_q  <= operand_bits_i;
    end
    if (out_load) begin
      res_q    <= conv.res;
      inx_q    <= conv.inx;
      inc_q    <= conv.inc;
      sticky_q <= flag_d;
      sum_q    <= conv.bad && !flag_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign result_bits_o          = res_q;
  assign inexact_o              = inx_q;
  assign rounded_up_magnitude_o = inc_q;
  assign invalid_sticky_o       = sticky_q;
  assign summary_set_o          = sum_q;

  `ASSERT_IMPL(a_sum_implies_sticky, clk_i, rst_ni, !out_valid_q || !sum_q || sticky_q)
  `ASSERT_IMPL(a_flag_inc_inx, clk_i, rst_ni, !out_valid_q || !inc_q || inx_q)
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_q && !out_ready_i,
               out_valid_q && $stable(res_q))

endmodule
